### src/bpvc_pkg.sv
// ----------------------------------------------------------------------------
// bpvc_pkg
// Shared types and constants for the bit position vote counter.
// ----------------------------------------------------------------------------
package bpvc_pkg;

  localparam int NUM_WORDS      = 16;
  localparam int COUNTER_BITS   = 32;
  localparam int WORD_BITS      = 64;
  localparam int INDEX_BITS     = 4;
  localparam int CMD_BITS       = 2;
  localparam int THRESH_BITS    = 32;
  localparam int ROW_AW         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int ROW_BITS       = WORD_BITS * COUNTER_BITS;
  localparam int CMP_BITS       = (COUNTER_BITS > THRESH_BITS) ? COUNTER_BITS : THRESH_BITS;

  typedef logic [COUNTER_BITS-1:0] count_t;
  typedef logic [THRESH_BITS-1:0]  thresh_t;
  typedef logic [WORD_BITS-1:0]    word_t;
  typedef logic [INDEX_BITS-1:0]   index_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ACCUMULATE = 2'd0,
    CMD_READ       = 2'd1,
    CMD_CLEAR      = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic   push;
    word_t  mask;
    index_t index;
  } mask_push_t;

endpackage

### src/bpvc_lane.sv
// ----------------------------------------------------------------------------
// bpvc_lane
// One counter lane: saturating increment and threshold compare.
// ----------------------------------------------------------------------------
module bpvc_lane (
  input  bpvc_pkg::count_t  count,
  input  logic              hit,
  input  bpvc_pkg::thresh_t threshold,
  output bpvc_pkg::count_t  count_next,
  output logic              below
);
  import bpvc_pkg::*;

  logic [CMP_BITS-1:0] count_ext;
  logic [CMP_BITS-1:0] thresh_ext;

  assign count_ext  = CMP_BITS'(count);
  assign thresh_ext = CMP_BITS'(threshold);
  assign below      = count_ext < thresh_ext;

  always_comb begin
    count_next = count;
    if (hit && (count != {COUNTER_BITS{1'b1}})) begin
      count_next = count + count_t'(1);
    end
  end

endmodule

### src/bpvc_mask_out.sv
// ----------------------------------------------------------------------------
// bpvc_mask_out
// Merge stage: gathers lane flags into the mask and holds the result request.
// ----------------------------------------------------------------------------
module bpvc_mask_out (
  input  logic                    clk,
  input  logic                    rst,
  input  bpvc_pkg::mask_push_t    push_req,
  input  logic                    in_range,
  output logic                    slot_free,
  output logic                    out_valid,
  input  logic                    out_ready,
  output bpvc_pkg::word_t         mask_word,
  output bpvc_pkg::index_t        mask_index
);
  import bpvc_pkg::*;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_req.push && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_req.push && slot_free) begin
      mask_word  <= in_range ? push_req.mask : '0;
      mask_index <= push_req.index;
    end
  end

endmodule

### src/bit_position_vote_counter.sv
// ----------------------------------------------------------------------------
// bit_position_vote_counter
// Per-bit saturating counters over a bitset, with threshold mask readout.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+-----
//   cfg     | cfg_valid cfg_ready cfg_data              | in
//   in      | in_valid in_ready command word_index word_bits | in
//   out     | out_valid out_ready mask_word mask_index  | out
//
// Each request first does the registered row read; then the
// 64 lanes update or compare and write the row back.
// A read holds in the execute state while the output register is occupied.
// Reset and clear drop all per-row valid bits at once; no sweep.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module bit_position_vote_counter (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  bpvc_pkg::thresh_t        cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [bpvc_pkg::CMD_BITS-1:0] command,
  input  bpvc_pkg::index_t         word_index,
  input  bpvc_pkg::word_t          word_bits,
  output logic                     out_valid,
  input  logic                     out_ready,
  output bpvc_pkg::word_t          mask_word,
  output bpvc_pkg::index_t         mask_index
);
  import bpvc_pkg::*;

  state_t               state;
  state_t               state_next;
  thresh_t              count_threshold;
  logic [CMD_BITS-1:0]  cmd_q;
  index_t               idx_q;
  word_t                bits_q;
  logic                 in_range_q;
  logic                 row_hit_q;
  logic [ROW_BITS-1:0]  row_mem [NUM_WORDS];
  logic [ROW_BITS-1:0]  row_rd;
  logic [ROW_BITS-1:0]  row_cur;
  logic [ROW_BITS-1:0]  row_wr;
  logic [NUM_WORDS-1:0] row_valid;
  logic [WORD_BITS-1:0] lane_below;
  logic [ROW_AW-1:0]    rd_addr;
  logic [ROW_AW-1:0]    wr_addr;
  logic                 accept;
  logic                 in_range;
  logic                 row_we;
  logic                 clear_all;
  logic                 done;
  logic                 slot_free;
  mask_push_t           push_req;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign in_range  = 32'(word_index) < NUM_WORDS;
  assign rd_addr   = ROW_AW'(word_index);
  assign wr_addr   = ROW_AW'(idx_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      count_threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      count_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q      <= command;
      idx_q      <= word_index;
      bits_q     <= word_bits;
      in_range_q <= in_range;
      row_hit_q  <= in_range && row_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_rd <= row_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[wr_addr] <= row_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      row_valid <= '0;
    end else if (row_we) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  assign row_cur = row_hit_q ? row_rd : '0;

  for (genvar l = 0; l < WORD_BITS; l++) begin : g_lane
    bpvc_lane u_lane (
      .count      (row_cur[l*COUNTER_BITS +: COUNTER_BITS]),
      .hit        (bits_q[l]),
      .threshold  (count_threshold),
      .count_next (row_wr[l*COUNTER_BITS +: COUNTER_BITS]),
      .below      (lane_below[l])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    row_we         = 1'b0;
    clear_all      = 1'b0;
    done           = 1'b0;
    push_req.push  = 1'b0;
    push_req.mask  = lane_below;
    push_req.index = idx_q;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_EXEC: begin
        case (cmd_q)
          CMD_ACCUMULATE: begin
            row_we = in_range_q;
            done   = 1'b1;
          end
          CMD_READ: begin
            push_req.push = 1'b1;
            done          = slot_free;
          end
          CMD_CLEAR: begin
            clear_all = 1'b1;
            done      = 1'b1;
          end
          default: done = 1'b1;
        endcase
      end
      default: in_ready = 1'b0;
    endcase
  end

  bpvc_mask_out u_mask_out (
    .clk        (clk),
    .rst        (rst),
    .push_req   (push_req),
    .in_range   (in_range_q),
    .slot_free  (slot_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mask_word  (mask_word),
    .mask_index (mask_index)
  );

endmodule

### test/tb_vote_mask_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vote_mask_checker
// Watches the threshold, request and mask channels of the vote counter, keeps
// its own copy of the per-bit counters and the threshold, works out the mask
// of every read request and compares each mask result against the oldest one
// still waiting. Hands the failure count and the number of masks still owed
// back to the testbench top.
// ----------------------------------------------------------------------------
module tb_vote_mask_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  bpvc_pkg::thresh_t               cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [bpvc_pkg::CMD_BITS-1:0]   command,
  input  bpvc_pkg::index_t                word_index,
  input  bpvc_pkg::word_t                 word_bits,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  bpvc_pkg::word_t                 mask_word,
  input  bpvc_pkg::index_t                mask_index,
  output int                              misses,
  output int                              outstanding
);
  import bpvc_pkg::*;

  typedef struct packed {
    word_t  mask;
    index_t index;
  } mask_result_t;

  count_t       vote_counts [NUM_WORDS*WORD_BITS];
  thresh_t      threshold;
  mask_result_t owed_masks [$];

  task automatic clear_votes();
    foreach (vote_counts[k]) vote_counts[k] = '0;
  endtask

  always @(posedge clk) begin
    mask_result_t want;
    mask_result_t fresh;
    int           base;
    if (rst) begin
      clear_votes();
      threshold = '0;
      owed_masks.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_masks.size() == 0) begin
          $error("unexpected mask result: mask_index %0d mask_word %h", mask_index, mask_word);
          misses++;
        end else begin
          want = owed_masks.pop_front();
          if (mask_word !== want.mask) begin
            $error("mask_word mismatch: expected %h, got %h", want.mask, mask_word);
            misses++;
          end
          if (mask_index !== want.index) begin
            $error("mask_index mismatch: expected %0d, got %0d", want.index, mask_index);
            misses++;
          end
        end
      end
      if (cfg_valid && cfg_ready) threshold = cfg_data;
      if (in_valid && in_ready) begin
        base = int'(word_index) * WORD_BITS;
        case (command)
          CMD_ACCUMULATE: begin
            if (word_index < NUM_WORDS)
              for (int i = 0; i < WORD_BITS; i++)
                if (word_bits[i] && vote_counts[base + i] != '1) vote_counts[base + i]++;
          end
          CMD_READ: begin
            fresh.index = word_index;
            fresh.mask  = '0;
            if (word_index < NUM_WORDS)
              for (int i = 0; i < WORD_BITS; i++)
                fresh.mask[i] = vote_counts[base + i] < threshold;
            owed_masks.push_back(fresh);
          end
          CMD_CLEAR: clear_votes();
          default: ;
        endcase
      end
    end
    outstanding = owed_masks.size();
  end

endmodule

### test/tb_bit_position_vote_counter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bit_position_vote_counter
// Drives accumulate, read, clear and unused requests into the vote counter
// and changes the threshold between phases. A directed opening covers the
// field extremes and every command; random bursts of accumulates followed by
// reads of the same word then run under several sender and receiver idling
// patterns, with one long receiver hold-off. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_bit_position_vote_counter;
  import bpvc_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
  localparam int PHASE_ITEMS   = 220;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int TIMEOUT_NS    = 2_000_000;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  thresh_t             cfg_data   = '0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic [CMD_BITS-1:0] command    = CMD_ACCUMULATE;
  index_t              word_index = '0;
  word_t               word_bits  = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  word_t               mask_word;
  index_t              mask_index;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   items_sent     = 0;
  logic hold_kick      = 1'b0;
  logic hold_seen      = 1'b0;
  int   hold_left      = 0;
  int   misses;
  int   outstanding;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bit_position_vote_counter u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .word_index (word_index),
    .word_bits  (word_bits),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mask_word  (mask_word),
    .mask_index (mask_index)
  );

  tb_vote_mask_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .word_index  (word_index),
    .word_bits   (word_bits),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mask_word   (mask_word),
    .mask_index  (mask_index),
    .misses      (misses),
    .outstanding (outstanding)
  );

  // hold off for a long stretch on each toggle of hold_kick
  always @(negedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic word_t random_bits();
    word_t a;
    word_t b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return a & b;
      3:       return a & b & {$urandom, $urandom};
      4:       return a | b;
      default: return a;
    endcase
  endfunction

  function automatic thresh_t random_threshold();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return thresh_t'(1);
      default: return thresh_t'($urandom_range(10));
    endcase
  endfunction

  task automatic send_req(input logic [CMD_BITS-1:0] cmd, input index_t idx, input word_t bits);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    word_index <= idx;
    word_bits  <= bits;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input thresh_t value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // accumulate into one word, then read it back; now and then some noise
  task automatic send_burst();
    index_t row;
    row = index_t'($urandom_range(15));
    repeat ($urandom_range(1, 12)) send_req(CMD_ACCUMULATE, row, random_bits());
    repeat ($urandom_range(1, 3)) send_req(CMD_READ, row, random_bits());
    case ($urandom_range(19))
      0: send_req(CMD_CLEAR, index_t'($urandom_range(15)), random_bits());
      1: send_req(CMD_UNUSED, index_t'($urandom_range(15)), random_bits());
      2: send_req(CMD_READ, index_t'($urandom_range(15)), random_bits());
      3: send_req(CMD_ACCUMULATE, index_t'($urandom_range(15)), random_bits());
      default: ;
    endcase
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int target;
    target         = items_sent + PHASE_ITEMS;
    send_idle_pct  = idle_pct;
    recv_stall_pct <= stall_pct;
    write_threshold(random_threshold());
    while (items_sent < target - PHASE_ITEMS/2) send_burst();
    write_threshold(random_threshold());
    while (items_sent < target) send_burst();
  endtask

  // fill the block while the receiver holds off
  task automatic hold_and_fill();
    send_idle_pct = 0;
    hold_kick <= ~hold_kick;
    repeat (40) send_req(CMD_READ, index_t'($urandom_range(15)), random_bits());
    drain();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_req(CMD_READ, 0, '1);
    write_threshold(1);
    send_req(CMD_READ, 0, '0);
    send_req(CMD_ACCUMULATE, 0, '1);
    send_req(CMD_ACCUMULATE, 15, 64'hAAAA_AAAA_AAAA_AAAA);
    send_req(CMD_READ, 0, '0);
    send_req(CMD_READ, 15, '0);
    send_req(CMD_UNUSED, 15, '1);
    send_req(CMD_ACCUMULATE, 15, '0);
    send_req(CMD_READ, 15, '0);
    send_req(CMD_CLEAR, 7, '1);
    send_req(CMD_READ, 15, '0);
    write_threshold('1);
    send_req(CMD_ACCUMULATE, 5, 64'h8000_0000_0000_0001);
    send_req(CMD_ACCUMULATE, 5, 64'h8000_0000_0000_0000);
    send_req(CMD_READ, 5, '0);
    write_threshold(2);
    send_req(CMD_READ, 5, '0);
    send_req(CMD_ACCUMULATE, 5, 64'h5555_5555_5555_5555);
    send_req(CMD_READ, 5, '1);
    send_req(CMD_CLEAR, 0, '0);
    send_req(CMD_READ, 5, '0);

    run_phase(0, 0);
    hold_and_fill();
    run_phase(80, 0);
    run_phase(0, 80);
    run_phase(8, 8);
    drain();

    if (misses == 0 && outstanding == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule
